// ===== rtl/sbl_pkg.sv =====
// Shared types and constants for the Sobel edge threshold block.
package sbl_pkg;

   localparam int PIX_W        = 8;
   localparam int POS_W        = 10;
   localparam int GRAD_W       = 11;
   localparam int CSR_W        = 11;
   localparam int CSR_IDX_W    = 2;
   localparam int MIN_SIZE     = 3;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int CENTRE_MIN   = 2;

   localparam logic [CSR_W-1:0] THRESHOLD_RESET = 11'd50;
   localparam logic [CSR_W-1:0] WIDTH_RESET     = 11'd1000;
   localparam logic [CSR_W-1:0] HEIGHT_RESET    = 11'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EDGE_THRESHOLD = 2'd0,
      CSR_IMAGE_WIDTH    = 2'd1,
      CSR_IMAGE_HEIGHT   = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/sbl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sbl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sobel_edge_threshold.sv =====
// Top level of the streaming 3x3 Sobel edge detector with squared-magnitude threshold.
//
//  Channel  Ports                                   Direction  Moves
//  req      req_valid/req_ready, req_pixel          in         one pixel item
//  rsp      rsp_valid/rsp_ready, rsp_center_*, ...  out        one result item
//  csr      csr_valid/csr_ready, csr_index/data     in         one register write
//
// One pixel is taken per cycle while req_ready is high.
// The line store RAM is read when a pixel is taken and written back as it leaves stage 1.
// After reset a clearing pass zeroes all MAX_WIDTH line store entries; req_ready is low.
// A stalled result holds the output register; stages behind it fill before req_ready drops.
module sobel_edge_threshold #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sbl_pkg::PIX_W-1:0]       req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sbl_pkg::POS_W-1:0]       rsp_center_row,
   output logic [sbl_pkg::POS_W-1:0]       rsp_center_col,
   output logic signed [sbl_pkg::GRAD_W-1:0] rsp_grad_x,
   output logic signed [sbl_pkg::GRAD_W-1:0] rsp_grad_y,
   output logic                            rsp_is_edge,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbl_pkg::CSR_W-1:0]       csr_data
);
   import sbl_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = CSR_W;
   localparam int SQ_W = 2 * GRAD_W;

   logic [CSR_W-1:0] threshold_ff, image_width_ff, image_height_ff;
   logic [WW-1:0] width_eff;
   logic [HW-1:0] height_eff;

   logic          clear_ff, clear_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   logic [AW-1:0]    col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;

   logic             s1_v_ff, s1_v_in, s1_produce_ff, s1_last_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic [POS_W-1:0] s1_row_ff, s1_col_ff;

   logic                     s2_v_ff, s2_v_in, s2_last_ff;
   logic [POS_W-1:0]         s2_row_ff, s2_col_ff;
   logic signed [GRAD_W-1:0] s2_gx_ff, s2_gy_ff;

   logic                     s3_v_ff, s3_v_in, s3_last_ff;
   logic [POS_W-1:0]         s3_row_ff, s3_col_ff;
   logic signed [GRAD_W-1:0] s3_gx_ff, s3_gy_ff;
   logic [SQ_W-2:0]          s3_gx2_ff, s3_gy2_ff;
   logic [SQ_W-1:0]          s3_thr2_ff;

   logic                     out_v_ff, out_v_in, out_edge_ff, out_last_ff;
   logic [POS_W-1:0]         out_row_ff, out_col_ff;
   logic signed [GRAD_W-1:0] out_gx_ff, out_gy_ff;

   logic out_en, s3_en, s2_en, s1_en, accept;

   logic          wrap_col;
   logic [AW-1:0] cur_c, cur_cm1;
   logic [HW-1:0] r_step, r_inc;
   logic [POS_W-1:0] cur_r;
   logic [WW-1:0] c_inc;
   logic          produce, last;

   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic signed [GRAD_W:0] gx_full, gy_full;
   logic signed [SQ_W-1:0] gx_sq, gy_sq;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [2*PIX_W-1:0]  ram_wdata, ram_rdata;

   // Register file.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EDGE_THRESHOLD: threshold_ff    <= csr_data;
            CSR_IMAGE_WIDTH:    image_width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT:   image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (image_width_ff < CSR_W'(MIN_SIZE)) begin
         width_eff = WW'(MIN_SIZE);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(image_width_ff);
      end
      if (image_height_ff < HW'(MIN_SIZE)) begin
         height_eff = HW'(MIN_SIZE);
      end else if (image_height_ff > HW'(HEIGHT_LIMIT)) begin
         height_eff = HW'(HEIGHT_LIMIT);
      end else begin
         height_eff = image_height_ff;
      end
   end

   // Stage enables: each stage loads when it is empty or its successor moves on.
   assign out_en    = !out_v_ff || rsp_ready;
   assign s3_en     = !s3_v_ff || out_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_ready = !clear_ff && s1_en;
   assign accept    = req_valid && req_ready;

   // Position of the incoming pixel and the counters after it.
   always_comb begin
      wrap_col = WW'(col_ff) >= width_eff;
      cur_c    = wrap_col ? '0 : col_ff;
      r_step   = wrap_col ? HW'(row_ff) + 1'b1 : HW'(row_ff);
      cur_r    = (r_step >= height_eff) ? '0 : r_step[POS_W-1:0];
      c_inc    = WW'(cur_c) + 1'b1;
      r_inc    = HW'(cur_r) + 1'b1;
      cur_cm1  = cur_c - 1'b1;
      produce  = (cur_r >= POS_W'(CENTRE_MIN)) && (cur_c >= AW'(CENTRE_MIN));
      last     = (HW'(cur_r) == height_eff - 1'b1) && (WW'(cur_c) == width_eff - 1'b1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (c_inc >= width_eff) begin
            col_in = '0;
            row_in = (r_inc >= height_eff) ? '0 : r_inc[POS_W-1:0];
         end else begin
            col_in = c_inc[AW-1:0];
            row_in = cur_r;
         end
      end
   end

   // Clearing pass over the line store after reset.
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == AW'(MAX_WIDTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   // Line store: each entry holds the pixel two rows up and one row up at a column.
   always_comb begin
      if (clear_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clear_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = s1_v_ff && s2_en;
         ram_waddr = s1_addr_ff;
         ram_wdata = {ram_rdata[PIX_W-1:0], s1_pixel_ff};
      end
   end

   sbl_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (cur_c),
      .rd_data (ram_rdata)
   );

   // Stage 1 holds the pixel while the line store is read.
   assign s1_v_in = s1_en ? accept : s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff   <= req_pixel;
         s1_addr_ff    <= cur_c;
         s1_produce_ff <= produce;
         s1_last_ff    <= last;
         s1_row_ff     <= cur_r - 1'b1;
         s1_col_ff     <= POS_W'(cur_cm1);
      end
   end

   // Window shift and gradients.
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = ram_rdata[2*PIX_W-1:PIX_W];
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = ram_rdata[PIX_W-1:0];
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_pixel_ff;
      gx_full = $signed({4'b0, win_in[2]}) - $signed({4'b0, win_in[0]})
              + $signed({3'b0, win_in[5], 1'b0}) - $signed({3'b0, win_in[3], 1'b0})
              + $signed({4'b0, win_in[8]}) - $signed({4'b0, win_in[6]});
      gy_full = $signed({4'b0, win_in[0]}) + $signed({3'b0, win_in[1], 1'b0})
              + $signed({4'b0, win_in[2]}) - $signed({4'b0, win_in[6]})
              - $signed({3'b0, win_in[7], 1'b0}) - $signed({4'b0, win_in[8]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_v_ff && s2_en) begin
         win_ff <= win_in;
      end
   end

   // Stage 2 keeps only pixels that centre an interior window.
   assign s2_v_in = s2_en ? (s1_v_ff && s1_produce_ff) : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_v_ff) begin
         s2_gx_ff   <= gx_full[GRAD_W-1:0];
         s2_gy_ff   <= gy_full[GRAD_W-1:0];
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage 3 squares the gradients and the threshold.
   assign gx_sq   = SQ_W'(s2_gx_ff) * SQ_W'(s2_gx_ff);
   assign gy_sq   = SQ_W'(s2_gy_ff) * SQ_W'(s2_gy_ff);
   assign s3_v_in = s3_en ? s2_v_ff : s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en && s2_v_ff) begin
         s3_gx2_ff  <= gx_sq[SQ_W-2:0];
         s3_gy2_ff  <= gy_sq[SQ_W-2:0];
         s3_thr2_ff <= SQ_W'(threshold_ff) * SQ_W'(threshold_ff);
         s3_gx_ff   <= s2_gx_ff;
         s3_gy_ff   <= s2_gy_ff;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Output register with the magnitude compare.
   assign out_v_in = out_en ? s3_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s3_v_ff) begin
         out_edge_ff <= (SQ_W'(s3_gx2_ff) + SQ_W'(s3_gy2_ff)) > s3_thr2_ff;
         out_gx_ff   <= s3_gx_ff;
         out_gy_ff   <= s3_gy_ff;
         out_row_ff  <= s3_row_ff;
         out_col_ff  <= s3_col_ff;
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_center_row = out_row_ff;
   assign rsp_center_col = out_col_ff;
   assign rsp_grad_x     = out_gx_ff;
   assign rsp_grad_y     = out_gy_ff;
   assign rsp_is_edge    = out_edge_ff;
   assign rsp_frame_last = out_last_ff;

`ifndef SYNTH
   a_no_item_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!req_ready && !s1_v_ff))
      else $error("Item in flight during line store clearing.");

   a_no_rmw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && accept && !clear_ff) |-> (ram_waddr != cur_c))
      else $error("Line store write-back and read hit the same column.");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_valid) |=> (WW'(col_ff) < width_eff))
      else $error("Column counter left the active width.");

   a_centre_row_interior: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> (s2_row_ff != '0))
      else $error("Result centred on the top border row.");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the streaming Sobel edge detector with threshold.
`timescale 1ns / 100ps

module tb;
   import sbl_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 470;
   localparam int WIDE_ITEMS    = 40;

   typedef struct {
      logic [POS_W-1:0]         centre_row;
      logic [POS_W-1:0]         centre_col;
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic                     edge_flag;
      logic                     frame_last;
   } gradient_item_type;

   class gradient_scoreboard;
      logic [CSR_W-1:0]  threshold;
      logic [CSR_W-1:0]  width_reg;
      logic [CSR_W-1:0]  height_reg;
      logic [PIX_W-1:0]  row_above [MAX_WIDTH];
      logic [PIX_W-1:0]  row_two_above [MAX_WIDTH];
      logic [PIX_W-1:0]  win [9];
      int unsigned       col_pos;
      int unsigned       row_pos;
      gradient_item_type expected_gradients [$];
      int                mismatch_count;

      function new();
         threshold  = THRESHOLD_RESET;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col_pos        = 0;
         row_pos        = 0;
         mismatch_count = 0;
      endfunction

      function int unsigned clamp_size(int unsigned v, int unsigned hi);
         if (v < MIN_SIZE) return MIN_SIZE;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_EDGE_THRESHOLD: threshold = value;
            CSR_IMAGE_WIDTH:    width_reg = value;
            CSR_IMAGE_HEIGHT:   height_reg = value;
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [PIX_W-1:0] p);
         int unsigned       w, h, c, r;
         int                gx, gy;
         gradient_item_type res;
         w = clamp_size(width_reg, MAX_WIDTH);
         h = clamp_size(height_reg, HEIGHT_LIMIT);
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         c = col_pos;
         r = row_pos;
         for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
         end
         win[2] = row_two_above[c];
         win[5] = row_above[c];
         win[8] = p;
         row_two_above[c] = row_above[c];
         row_above[c]     = p;
         if (r >= CENTRE_MIN && c >= CENTRE_MIN) begin
            gx = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
               - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
            gy = int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
               - int'(win[6]) - 2 * int'(win[7]) - int'(win[8]);
            res.centre_row = POS_W'(r - 1);
            res.centre_col = POS_W'(c - 1);
            res.grad_x     = GRAD_W'(gx);
            res.grad_y     = GRAD_W'(gy);
            res.edge_flag  = (gx * gx + gy * gy) > int'(threshold) * int'(threshold);
            res.frame_last = (r == h - 1) && (c == w - 1);
            expected_gradients = {expected_gradients, res};
         end
         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void compare_field(string name, int expv, int actv);
         if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            mismatch_count++;
         end
      endfunction

      function void check_result(gradient_item_type got);
         gradient_item_type want;
         if (expected_gradients.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual row %0d col %0d",
                     $time, got.centre_row, got.centre_col);
            mismatch_count++;
            return;
         end
         want = expected_gradients.pop_front();
         compare_field("centre_row", want.centre_row, got.centre_row);
         compare_field("centre_col", want.centre_col, got.centre_col);
         compare_field("grad_x", want.grad_x, got.grad_x);
         compare_field("grad_y", want.grad_y, got.grad_y);
         compare_field("is_edge", want.edge_flag, got.edge_flag);
         compare_field("frame_last", want.frame_last, got.frame_last);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [POS_W-1:0]         rsp_center_row;
   logic [POS_W-1:0]         rsp_center_col;
   logic signed [GRAD_W-1:0] rsp_grad_x;
   logic signed [GRAD_W-1:0] rsp_grad_y;
   logic                     rsp_is_edge;
   logic                     rsp_frame_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   csr_index_type            csr_index = CSR_EDGE_THRESHOLD;
   logic [CSR_W-1:0]         csr_data = '0;

   gradient_scoreboard sb = new();
   bit                 send_burst = 1'b0;
   bit                 rsp_burst = 1'b0;
   int                 stall_cycles = 0;

   sobel_edge_threshold #(.MAX_WIDTH(MAX_WIDTH)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_is_edge    (rsp_is_edge),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   task automatic send_pixel(input logic [PIX_W-1:0] p);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_pixel(p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_gradients.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_W-1:0] vals [3], input bit [2:0] sel);
      for (int i = 0; i < 3; i++) begin
         if (sel[i]) begin
            csr_valid <= 1'b1;
            csr_index <= csr_index_type'(i);
            csr_data  <= vals[i];
            do @(posedge clock); while (csr_ready !== 1'b1);
            sb.write_register(csr_index_type'(i), vals[i]);
         end
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int                gap;
      gradient_item_type got;
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         got.centre_row = rsp_center_row;
         got.centre_col = rsp_center_col;
         got.grad_x     = rsp_grad_x;
         got.grad_y     = rsp_grad_y;
         got.edge_flag  = rsp_is_edge;
         got.frame_last = rsp_frame_last;
         sb.check_result(got);
         if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || (csr_valid && csr_ready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[sobel_edge_threshold] ERROR");
         $finish;
      end
   end

   initial begin
      logic [CSR_W-1:0] vals [3];
      bit [2:0]         sel;
      int               phase_len;
      int               mode;
      int               sent;
      logic [PIX_W-1:0] pix;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Full-scale gradients on the smallest frame: a bright right column, then a bright
      // bottom row.
      vals = '{11'd0, 11'd3, 11'd3};
      apply_settings(vals, 3'b111);
      for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'hFF : 8'h00);
      for (int i = 0; i < 9; i++) send_pixel((i / 3 == 2) ? 8'hFF : 8'h00);
      drain();

      // An oversized width is limited, then a narrow width mid-frame pushes the next
      // item onto a new row.
      vals = '{CSR_W'($urandom_range(0, 400)), 11'd2047, 11'd3};
      apply_settings(vals, 3'b111);
      for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(PIX_W'($urandom_range(0, 255)));
      drain();
      vals[1] = 11'd4;
      apply_settings(vals, 3'b010);
      for (int i = 0; i < 12; i++) send_pixel(PIX_W'($urandom_range(0, 255)));

      sent = 0;
      pix  = '0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         send_burst = 1'b0;
         sel = 3'($urandom_range(1, 7));
         case ($urandom_range(0, 5))
            0:       vals[0] = 11'd0;
            1:       vals[0] = 11'd1443;
            2:       vals[0] = 11'd2047;
            default: vals[0] = CSR_W'($urandom_range(0, 400));
         endcase
         case ($urandom_range(0, 7))
            0:       vals[1] = CSR_W'($urandom_range(0, 2));
            1:       vals[1] = CSR_W'($urandom_range(1025, 2047));
            default: vals[1] = CSR_W'($urandom_range(3, 10));
         endcase
         case ($urandom_range(0, 7))
            0:       vals[2] = CSR_W'($urandom_range(0, 2));
            1:       vals[2] = 11'd2047;
            default: vals[2] = CSR_W'($urandom_range(3, 8));
         endcase
         apply_settings(vals, sel);
         send_burst = ($urandom_range(0, 4) == 0);
         mode       = $urandom_range(0, 2);
         phase_len  = $urandom_range(10, 60);
         for (int i = 0; i < phase_len; i++) begin
            case (mode)
               0:       pix = PIX_W'($urandom_range(0, 255));
               1:       pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default: pix = pix + PIX_W'($urandom_range(0, 30)) - 8'd15;
            endcase
            send_pixel(pix);
         end
         sent += phase_len;
      end
      drain();
      repeat (20) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.expected_gradients.size() == 0) begin
         $display("[sobel_edge_threshold] OK");
      end else begin
         $display("[sobel_edge_threshold] ERROR");
      end
      $finish;
   end

endmodule
